// File: hdl/imu_fifo_record_realign_macros.svh
// Assertion helpers for the checker file of the record realigner.
`ifndef IMU_FIFO_RECORD_REALIGN_MACROS_SVH
`define IMU_FIFO_RECORD_REALIGN_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define IMU_FRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define IMU_FRR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/imu_frr_pkg.sv
package imu_frr_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned TripleW = 3 * WordW;
  localparam int unsigned HoldDepth = 4;
  localparam int unsigned HoldIdxW = $clog2(HoldDepth);
  localparam int unsigned CountW = 3;

  localparam logic [CountW-1:0] CountDecided = 3'd4;
  localparam logic [CountW-1:0] CountLastHold = 3'd3;

  typedef logic [TripleW-1:0] triple_t;

  typedef struct packed {
    logic signed [WordW-1:0] acc_x;
    logic signed [WordW-1:0] acc_y;
    logic signed [WordW-1:0] acc_z;
    logic signed [WordW-1:0] rate_x;
    logic signed [WordW-1:0] rate_y;
    logic signed [WordW-1:0] rate_z;
    logic                    batch_end;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] rate_x_out;
    logic signed [WordW-1:0] rate_y_out;
    logic signed [WordW-1:0] rate_z_out;
    logic                    acc_valid;
    logic signed [WordW-1:0] acc_x_out;
    logic signed [WordW-1:0] acc_y_out;
    logic signed [WordW-1:0] acc_z_out;
    logic                    bad_batch;
    logic                    final_out;
  } out_t;

  typedef struct packed {
    logic acc_valid;
    logic bad;
    logic fin;
  } emit_ctl_t;

  typedef struct packed {
    logic phase;
    logic bad;
  } phase_t;

endpackage

// File: hdl/imu_frr_remap.sv
module imu_frr_remap (
  input  imu_frr_pkg::triple_t   acc_i,
  input  imu_frr_pkg::triple_t   gyr_i,
  input  imu_frr_pkg::emit_ctl_t ctl_i,
  output imu_frr_pkg::out_t      res_o
);
  import imu_frr_pkg::*;

  localparam logic [WordW-1:0] MinWord = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] MaxWord = {1'b0, {(WordW-1){1'b1}}};

  function automatic logic [WordW-1:0] neg_wrap(input logic [WordW-1:0] v);
    return (~v) + {{(WordW-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [WordW-1:0] neg_sat(input logic [WordW-1:0] v);
    return (v == MinWord) ? MaxWord : neg_wrap(v);
  endfunction

  always_comb begin
    res_o.rate_x_out = neg_sat(gyr_i[2*WordW-1:WordW]);
    res_o.rate_y_out = neg_wrap(gyr_i[WordW-1:0]);
    res_o.rate_z_out = neg_sat(gyr_i[3*WordW-1:2*WordW]);
    res_o.acc_valid  = ctl_i.acc_valid;
    if (ctl_i.acc_valid) begin
      res_o.acc_x_out = neg_sat(acc_i[2*WordW-1:WordW]);
      res_o.acc_y_out = neg_wrap(acc_i[WordW-1:0]);
      res_o.acc_z_out = neg_sat(acc_i[3*WordW-1:2*WordW]);
    end else begin
      res_o.acc_x_out = '0;
      res_o.acc_y_out = '0;
      res_o.acc_z_out = '0;
    end
    res_o.bad_batch = ctl_i.bad;
    res_o.final_out = ctl_i.fin;
  end

endmodule

// File: hdl/imu_frr_phase.sv
module imu_frr_phase (
  input  imu_frr_pkg::triple_t acc0_i,
  input  imu_frr_pkg::triple_t acc1_i,
  input  imu_frr_pkg::triple_t acc2_i,
  input  imu_frr_pkg::triple_t acc3_i,
  input  logic                 full_i,
  output imu_frr_pkg::phase_t  dec_o
);
  import imu_frr_pkg::*;

  logic pairs_match;
  logic mid_match;

  assign pairs_match = (acc0_i == acc1_i) && (acc2_i == acc3_i);
  assign mid_match   = (acc1_i == acc2_i);

  always_comb begin
    dec_o.phase = 1'b1;
    dec_o.bad   = 1'b0;
    if (full_i) begin
      priority if (pairs_match) begin
        dec_o.phase = 1'b1;
      end else if (mid_match) begin
        dec_o.phase = 1'b0;
      end else begin
        dec_o.bad = 1'b1;
      end
    end
  end

endmodule

// File: hdl/imu_fifo_record_realign.sv
// A streaming item passes through the input register and then the output register.
// Throughput: one item per cycle once the accel phase of a batch is decided, while the output is not stalled.
// An item that decides the phase releases up to four results, one per output
// cycle, and the input register holds the next item until they have left.
// Reset clears all control and batch state; held records need no reset.
module imu_fifo_record_realign (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  imu_frr_pkg::in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output imu_frr_pkg::out_t  out_o
);
  import imu_frr_pkg::*;

  logic              in_v_q, in_v_d;
  in_t               in_q;
  triple_t           cur_acc, cur_gyr;

  logic [CountW-1:0] count_q, count_d;
  logic              odd_q, odd_d;
  logic              phase_q, phase_d;
  logic              bad_q, bad_d;

  triple_t           hold_acc_q [HoldDepth];
  triple_t           hold_gyr_q [HoldDepth];

  logic                drain_q, drain_d;
  logic [HoldIdxW-1:0] drain_idx_q, drain_idx_d;
  logic [HoldIdxW-1:0] drain_top_q, drain_top_d;
  logic                drain_fin_q, drain_fin_d;
  phase_t              drain_dec_q, drain_dec_d;

  logic      out_v_q, out_v_d;
  out_t      out_q;
  logic      out_free;
  logic      is_stream, is_hold;
  logic      advance;
  logic      push_stream, push_drain;
  logic      hold_wr;
  phase_t    dec;
  triple_t   sel_acc, sel_gyr;
  emit_ctl_t ctl;
  out_t      res;

  assign cur_acc = {in_q.acc_z, in_q.acc_y, in_q.acc_x};
  assign cur_gyr = {in_q.rate_z, in_q.rate_y, in_q.rate_x};

  assign is_stream  = (count_q == CountDecided);
  assign is_hold    = !is_stream && (count_q != CountLastHold) && !in_q.batch_end;

  assign out_free    = !out_v_q || !out_stall_i;
  assign advance     = in_v_q && !drain_q && (!is_stream || out_free);
  assign in_stall_o  = in_v_q && !advance;
  assign push_drain  = drain_q && out_free;
  assign push_stream = advance && is_stream;
  assign hold_wr     = advance && !is_stream;

  imu_frr_phase u_phase (
    .acc0_i (hold_acc_q[0]),
    .acc1_i (hold_acc_q[1]),
    .acc2_i (hold_acc_q[2]),
    .acc3_i (cur_acc),
    .full_i (count_q == CountLastHold),
    .dec_o  (dec)
  );

  always_comb begin
    if (drain_q) begin
      sel_acc       = hold_acc_q[drain_idx_q];
      sel_gyr       = hold_gyr_q[drain_idx_q];
      ctl.acc_valid = (drain_idx_q[0] == drain_dec_q.phase);
      ctl.bad       = drain_dec_q.bad;
      ctl.fin       = drain_fin_q && (drain_idx_q == drain_top_q);
    end else begin
      sel_acc       = cur_acc;
      sel_gyr       = cur_gyr;
      ctl.acc_valid = (odd_q == phase_q);
      ctl.bad       = bad_q;
      ctl.fin       = in_q.batch_end;
    end
  end

  imu_frr_remap u_remap (
    .acc_i (sel_acc),
    .gyr_i (sel_gyr),
    .ctl_i (ctl),
    .res_o (res)
  );

  always_comb begin
    in_v_d      = in_stall_o ? 1'b1 : in_valid_i;
    count_d     = count_q;
    odd_d       = odd_q;
    phase_d     = phase_q;
    bad_d       = bad_q;
    drain_d     = drain_q;
    drain_idx_d = drain_idx_q;
    drain_top_d = drain_top_q;
    drain_fin_d = drain_fin_q;
    drain_dec_d = drain_dec_q;
    out_v_d     = out_free ? (push_drain || push_stream) : out_v_q;

    if (push_drain) begin
      if (drain_idx_q == drain_top_q) begin
        drain_d = 1'b0;
      end else begin
        drain_idx_d = drain_idx_q + 1'b1;
      end
    end

    if (advance) begin
      if (is_stream) begin
        odd_d = ~odd_q;
      end else if (is_hold) begin
        count_d = count_q + 1'b1;
      end else begin
        drain_d     = 1'b1;
        drain_idx_d = '0;
        drain_top_d = count_q[HoldIdxW-1:0];
        drain_fin_d = in_q.batch_end;
        drain_dec_d = dec;
        count_d     = CountDecided;
        odd_d       = ~count_q[0];
        phase_d     = dec.phase;
        bad_d       = dec.bad;
      end
      if (in_q.batch_end) begin
        count_d = '0;
        odd_d   = 1'b0;
        phase_d = 1'b1;
        bad_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q      <= 1'b0;
      count_q     <= '0;
      odd_q       <= 1'b0;
      phase_q     <= 1'b1;
      bad_q       <= 1'b0;
      drain_q     <= 1'b0;
      drain_idx_q <= '0;
      drain_top_q <= '0;
      drain_fin_q <= 1'b0;
      drain_dec_q <= '0;
      out_v_q     <= 1'b0;
    end else begin
      in_v_q      <= in_v_d;
      count_q     <= count_d;
      odd_q       <= odd_d;
      phase_q     <= phase_d;
      bad_q       <= bad_d;
      drain_q     <= drain_d;
      drain_idx_q <= drain_idx_d;
      drain_top_q <= drain_top_d;
      drain_fin_q <= drain_fin_d;
      drain_dec_q <= drain_dec_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_i;
    end
    if (hold_wr) begin
      hold_acc_q[count_q[HoldIdxW-1:0]] <= cur_acc;
      hold_gyr_q[count_q[HoldIdxW-1:0]] <= cur_gyr;
    end
    if (push_drain || push_stream) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// File: hdl/imu_frr_checker.sv
`include "imu_fifo_record_realign_macros.svh"

module imu_frr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input imu_frr_pkg::in_t  in_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input imu_frr_pkg::out_t out_o
);
  import imu_frr_pkg::*;

  localparam logic [WordW-1:0] MinWord = {1'b1, {(WordW-1){1'b0}}};

  logic acc_zero;
  logic no_min_sat;

  assign acc_zero = (out_o.acc_x_out == '0) && (out_o.acc_y_out == '0) &&
                    (out_o.acc_z_out == '0);
  assign no_min_sat = (out_o.rate_x_out != MinWord) && (out_o.rate_z_out != MinWord) &&
                      (out_o.acc_x_out != MinWord) && (out_o.acc_z_out != MinWord);

  `IMU_FRR_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_i), "stalled item changed")
  `IMU_FRR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o), "stalled result changed")
  `IMU_FRR_ASSERT(a_acc_blank, !out_valid_o || out_o.acc_valid || acc_zero, "accel words set without a sample")
  `IMU_FRR_ASSERT(a_sat_axes, !out_valid_o || no_min_sat, "saturating axis shows the most negative word")

endmodule

bind imu_fifo_record_realign imu_frr_checker u_imu_frr_checker (.*);
